// ===== rtl/tpeq_pkg.sv =====
// Shared types and constants for the two-priority event queue.
`default_nettype none

package tpeq_pkg;

	// Field widths
	localparam int CODE_W  = 8;
	localparam int PARAM_W = 16;
	localparam int ENTRY_W = CODE_W + PARAM_W;
	localparam int COUNT_W = 6;

	// Operation codes
	typedef enum logic [1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_POP   = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_EMPTY = 2'd3
	} func_t;

	// Queue select codes
	localparam logic PRI_HIGH = 1'b0;
	localparam logic PRI_LOW  = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/tpeq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tpeq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port; read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/two_priority_event_queue_unit.sv =====
// Top level of the two-priority event queue: pointer control, storage and result stage.
`default_nettype none

// Two ring FIFOs of QUEUE_DEPTH events (8-bit code, signed 16-bit parameter), high and low
// priority, each held in its own RAM with a registered read. For every operation (push, pop,
// clear overflow, empty both), pointers, fill counts and the overflow flag update at the input
// transfer, a push writes its RAM at that edge, and a pop reads the head entry at that edge so
// the data lands together with the result. The block takes one operation per cycle as long as
// the result side takes one per cycle; the single result register stalls the input while its
// result waits. A pop directly after a push to the same queue is safe, since the write
// completes before the next read is issued. Fill counts are reported modulo 64.
module two_priority_event_queue_unit #(
	parameter int QUEUE_DEPTH = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Operation channel
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [1:0]                            func,
	input  wire logic [tpeq_pkg::CODE_W-1:0]           code,
	input  wire logic signed [tpeq_pkg::PARAM_W-1:0]   param,
	input  wire logic                                  priority_req,
	// Result channel
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic                                       ok,
	output logic      [tpeq_pkg::CODE_W-1:0]           out_code,
	output logic signed [tpeq_pkg::PARAM_W-1:0]        out_param,
	output logic                                       out_priority,
	output logic      [tpeq_pkg::COUNT_W-1:0]          high_count,
	output logic      [tpeq_pkg::COUNT_W-1:0]          low_count,
	output logic                                       overflow
);

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

	tpeq_pkg::func_t op;

	// Queue state
	logic [PTR_W-1:0]  high_head_q, high_tail_q, low_head_q, low_tail_q;
	logic [FILL_W-1:0] high_fill_q, low_fill_q;
	logic              overflow_q;

	logic [PTR_W-1:0]  high_head_d, high_tail_d, low_head_d, low_tail_d;
	logic [FILL_W-1:0] high_fill_d, low_fill_d;
	logic              overflow_d;

	// Result stage
	logic                      valid_s1;
	logic                      ok_s1;
	logic                      pop_s1;
	logic                      pri_s1;
	logic [FILL_W-1:0]         high_fill_s1, low_fill_s1;
	logic                      overflow_s1;

	logic ok_d, pop_d, pri_d;

	// RAM ports
	logic                          high_we, low_we, high_re, low_re;
	logic [tpeq_pkg::ENTRY_W-1:0]  wdata;
	logic [tpeq_pkg::ENTRY_W-1:0]  high_rdata, low_rdata, sel_rdata;

	logic in_xfer;

	assign op       = tpeq_pkg::func_t'(func);
	assign in_ready = !valid_s1 || out_ready;
	assign in_xfer  = in_valid && in_ready;
	assign wdata    = {code, param};

	// Decode the operation and compute next queue state
	always_comb begin
		high_head_d = high_head_q;
		high_tail_d = high_tail_q;
		low_head_d  = low_head_q;
		low_tail_d  = low_tail_q;
		high_fill_d = high_fill_q;
		low_fill_d  = low_fill_q;
		overflow_d  = overflow_q;
		ok_d        = 1'b0;
		pop_d       = 1'b0;
		pri_d       = tpeq_pkg::PRI_HIGH;
		high_we     = 1'b0;
		low_we      = 1'b0;
		high_re     = 1'b0;
		low_re      = 1'b0;
		if (in_xfer) begin
			unique case (op)
				tpeq_pkg::FUNC_PUSH: begin
					if (priority_req == tpeq_pkg::PRI_LOW) begin
						if (low_fill_q != FILL_MAX) begin
							low_we      = 1'b1;
							low_tail_d  = (low_tail_q == PTR_LAST) ? '0 : low_tail_q + 1'b1;
							low_fill_d  = low_fill_q + 1'b1;
							ok_d        = 1'b1;
						end else begin
							overflow_d  = 1'b1;
						end
					end else begin
						if (high_fill_q != FILL_MAX) begin
							high_we     = 1'b1;
							high_tail_d = (high_tail_q == PTR_LAST) ? '0 : high_tail_q + 1'b1;
							high_fill_d = high_fill_q + 1'b1;
							ok_d        = 1'b1;
						end else begin
							overflow_d  = 1'b1;
						end
					end
				end
				tpeq_pkg::FUNC_POP: begin
					if (high_fill_q != '0) begin
						high_re     = 1'b1;
						high_head_d = (high_head_q == PTR_LAST) ? '0 : high_head_q + 1'b1;
						high_fill_d = high_fill_q - 1'b1;
						ok_d        = 1'b1;
						pop_d       = 1'b1;
						pri_d       = tpeq_pkg::PRI_HIGH;
					end else if (low_fill_q != '0) begin
						low_re      = 1'b1;
						low_head_d  = (low_head_q == PTR_LAST) ? '0 : low_head_q + 1'b1;
						low_fill_d  = low_fill_q - 1'b1;
						ok_d        = 1'b1;
						pop_d       = 1'b1;
						pri_d       = tpeq_pkg::PRI_LOW;
					end
				end
				tpeq_pkg::FUNC_CLEAR: begin
					overflow_d = 1'b0;
					ok_d       = 1'b1;
				end
				tpeq_pkg::FUNC_EMPTY: begin
					high_head_d = '0;
					high_tail_d = '0;
					low_head_d  = '0;
					low_tail_d  = '0;
					high_fill_d = '0;
					low_fill_d  = '0;
					overflow_d  = 1'b0;
					ok_d        = 1'b1;
				end
				default: begin
					ok_d = 1'b0;
				end
			endcase
		end
	end

	// Hold queue pointers, counts and flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_head_q <= '0;
			high_tail_q <= '0;
			low_head_q  <= '0;
			low_tail_q  <= '0;
			high_fill_q <= '0;
			low_fill_q  <= '0;
			overflow_q  <= 1'b0;
		end else begin
			high_head_q <= high_head_d;
			high_tail_q <= high_tail_d;
			low_head_q  <= low_head_d;
			low_tail_q  <= low_tail_d;
			high_fill_q <= high_fill_d;
			low_fill_q  <= low_fill_d;
			overflow_q  <= overflow_d;
		end
	end

	// Advance the result stage on each input transfer, drop it on output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ok_s1        <= ok_d;
			pop_s1       <= pop_d;
			pri_s1       <= pri_d;
			high_fill_s1 <= high_fill_d;
			low_fill_s1  <= low_fill_d;
			overflow_s1  <= overflow_d;
		end
	end

	// Event storage
	tpeq_ram #(
		.WIDTH (tpeq_pkg::ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_high_ram (
		.clk   (clk),
		.we    (high_we),
		.waddr (high_tail_q),
		.wdata (wdata),
		.re    (high_re),
		.raddr (high_head_q),
		.rdata (high_rdata)
	);

	tpeq_ram #(
		.WIDTH (tpeq_pkg::ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_low_ram (
		.clk   (clk),
		.we    (low_we),
		.waddr (low_tail_q),
		.wdata (wdata),
		.re    (low_re),
		.raddr (low_head_q),
		.rdata (low_rdata)
	);

	// Select popped entry, zero when nothing was popped
	assign sel_rdata = !pop_s1 ? '0 :
		((pri_s1 == tpeq_pkg::PRI_LOW) ? low_rdata : high_rdata);

	assign out_valid    = valid_s1;
	assign ok           = ok_s1;
	assign out_code     = sel_rdata[tpeq_pkg::ENTRY_W-1:tpeq_pkg::PARAM_W];
	assign out_param    = sel_rdata[tpeq_pkg::PARAM_W-1:0];
	assign out_priority = pop_s1 && pri_s1;
	assign high_count   = tpeq_pkg::COUNT_W'(high_fill_s1);
	assign low_count    = tpeq_pkg::COUNT_W'(low_fill_s1);
	assign overflow     = overflow_s1;

	// Fill counts never pass the queue depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		high_fill_q <= FILL_MAX && low_fill_q <= FILL_MAX)
		else $error("fill count above queue depth");

	// Accepted high push raises the high count by one
	a_push_high: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && op == tpeq_pkg::FUNC_PUSH && priority_req == tpeq_pkg::PRI_HIGH &&
		high_fill_q != FILL_MAX |=> high_fill_q == $past(high_fill_q) + 1'b1)
		else $error("high push did not advance fill count");

	// Pop from two empty queues fails and leaves state alone
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && op == tpeq_pkg::FUNC_POP && high_fill_q == '0 && low_fill_q == '0
		|=> !ok_s1 && !pop_s1 && high_fill_q == '0 && low_fill_q == '0)
		else $error("pop from empty queues changed state");

	// Empty operation zeroes both counts and the flag
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && op == tpeq_pkg::FUNC_EMPTY
		|=> high_fill_q == '0 && low_fill_q == '0 && !overflow_q && ok_s1)
		else $error("empty operation left state behind");

	// Refused push sets the sticky flag
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && op == tpeq_pkg::FUNC_PUSH && !ok_d |=> overflow_q && !ok_s1)
		else $error("refused push did not set overflow");

endmodule

`default_nettype wire
